FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Include guard plus small property wrappers; nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, masked during reset
`define QE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, masked during reset
`define QE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/qe_pkg.sv
// Package for the quaternion to Euler bin converter.
// Holds widths, CORDIC arctangent table and the pitch edge sine function.
`timescale 1ns / 1ps
`default_nettype none
package qe_pkg;
  localparam int BINS_DEF       = 18;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QW  = 16;   // input field width
  localparam int BW  = 5;    // bin width
  localparam int PW  = 36;   // product sum width
  localparam int CW  = 44;   // cordic x/y width
  localparam int AW  = 34;   // angle width
  localparam int MAXS = 32;

  typedef logic signed [QW-1:0] quat_t;
  typedef logic [BW-1:0]        bin_t;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat_item_t;

  typedef struct packed {
    bin_t roll;
    bin_t pitch;
    bin_t yaw;
  } bins_item_t;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic signed [AW-1:0] atan_units(input int i);
    logic [31:0] t [0:31];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
          32'h00000001, 32'h00000000};
    return AW'(signed'({2'b00, t[i & 31]}));
  endfunction

  // floor arithmetic shift, used at elaboration only
  function automatic longint asr_c(input longint v, input int n);
    return v >>> n;
  endfunction

  // sine of an edge angle in Q1.30 by CORDIC rotation; elaboration-time constant
  function automatic longint edge_sin(input longint theta, input int steps);
    longint x, y, z, dx, dy;
    int n;
    x = 652032874;
    y = 0;
    z = theta;
    n = (steps > 32) ? 32 : steps;
    for (int i = 0; i < n; i++) begin
      dx = asr_c(y, i);
      dy = asr_c(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_units(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_units(i));
      end
    end
    if (y > (longint'(1) <<< 30)) y = longint'(1) <<< 30;
    if (y < -(longint'(1) <<< 30)) y = -(longint'(1) <<< 30);
    return y;
  endfunction
endpackage
`default_nettype wire

FILE: sv/qe_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface qe_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/quaternion_to_euler_bins_top.sv
// Top level: quaternion in, roll/pitch/yaw bins out.
// Depends on qe_pkg, qe_if, qe_atan2_bin.
//
//  channel | dir | payload
//  in_     | in  | quat_w, quat_x, quat_y, quat_z (signed Q2.14)
//  out_    | out | roll_bin, pitch_bin, yaw_bin (0..BINS)
//
// One item per cycle sustained while the output is not stalled.
// Depth set by the per-step CORDIC stage chain in qe_atan2_bin.
// Whole pipe advances when the output register is empty or being taken.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_bins_top #(
  parameter int BINS = qe_pkg::BINS_DEF,
  parameter int CORDIC_STEPS = qe_pkg::CORDIC_STEPS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  qe_if.sink   in_ch,
  qe_if.source out_ch
);
  localparam int FRAC_BITS = qe_pkg::FRAC_BITS_DEF;
  localparam int N  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int PW = qe_pkg::PW;
  localparam int LAT = N + 4;   // stages up to bin registers
  localparam logic signed [PW-1:0] ONE = PW'(64'sd1 <<< (2*FRAC_BITS));

  logic en;
  logic [LAT-1:0] v_r;
  logic out_valid_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_ch.data.w * in_ch.data.x;
      yz_r <= in_ch.data.y * in_ch.data.z;
      xx_r <= in_ch.data.x * in_ch.data.x;
      yy_r <= in_ch.data.y * in_ch.data.y;
      wy_r <= in_ch.data.w * in_ch.data.y;
      zx_r <= in_ch.data.z * in_ch.data.x;
      wz_r <= in_ch.data.w * in_ch.data.z;
      xy_r <= in_ch.data.x * in_ch.data.y;
      zz_r <= in_ch.data.z * in_ch.data.z;
    end
  end

  // stage B: Euler products
  logic signed [PW-1:0] ry_r, rx_r, ps_r, yy2_r, yx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ry_r  <= (PW'(wx_r) + PW'(yz_r)) <<< 1;
      rx_r  <= ONE - ((PW'(xx_r) + PW'(yy_r)) <<< 1);
      ps_r  <= (PW'(wy_r) - PW'(zx_r)) <<< 1;
      yy2_r <= (PW'(wz_r) + PW'(xy_r)) <<< 1;
      yx_r  <= ONE - ((PW'(yy_r) + PW'(zz_r)) <<< 1);
    end
  end

  logic [qe_pkg::BW-1:0] roll_bin, yaw_bin;
  qe_atan2_bin #(.BINS(BINS), .STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .yv(ry_r), .xv(rx_r), .bin(roll_bin));
  qe_atan2_bin #(.BINS(BINS), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .yv(yy2_r), .xv(yx_r), .bin(yaw_bin));

  // pitch: clamp and scale to Q1.30
  localparam int SW = 34;
  logic signed [PW-1:0] sc;
  logic signed [SW-1:0] sq_nxt, sq_r;
  always_comb begin
    sc = ps_r;
    if (sc > ONE) sc = ONE;
    if (sc < -ONE) sc = -ONE;
    if (2*FRAC_BITS >= 30) sq_nxt = SW'(sc >>> (2*FRAC_BITS - 30));
    else sq_nxt = SW'(sc <<< (30 - 2*FRAC_BITS));
  end
  always_ff @(posedge clk) begin
    if (en) sq_r <= sq_nxt;
  end

  // edge compares, registered
  logic [BINS-1:0] ge_r;
  for (genvar j = 1; j <= BINS; j++) begin : g_edge
    localparam longint EA = -(longint'(1) <<< 30) +
                            ((longint'(j) <<< 31) / longint'(BINS));
    localparam longint ES = (j == BINS) ? (longint'(1) <<< 30)
                                        : qe_pkg::edge_sin(EA, CORDIC_STEPS);
    always_ff @(posedge clk) begin
      if (en) ge_r[j-1] <= (sq_r >= SW'(ES));
    end
  end

  // count of passed edges (thermometer), then delay to match CORDIC
  logic [7:0] cnt;
  always_comb begin
    cnt = '0;
    for (int k = 0; k < BINS; k++) cnt = cnt + 8'(ge_r[k]);
  end
  localparam int PD = N + 1;
  logic [qe_pkg::BW-1:0] pd_r [0:PD-1];
  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= cnt[qe_pkg::BW-1:0];
      for (int k = 1; k < PD; k++) pd_r[k] <= pd_r[k-1];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid};
      out_valid_r <= v_r[LAT-1];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data.roll = roll_bin;
  assign out_ch.data.yaw = yaw_bin;
  assign out_ch.data.pitch = pd_r[PD-1];
endmodule
`default_nettype wire

FILE: sv/qe_atan2_bin.sv
// Pipelined atan2 to full-turn bin: magnitudes, CORDIC vectoring, quadrant fold, bin.
// Depends on qe_pkg. Advances when en is high; one stage per CORDIC step.
`timescale 1ns / 1ps
`default_nettype none
module qe_atan2_bin #(
  parameter int BINS = qe_pkg::BINS_DEF,
  parameter int STEPS = qe_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [qe_pkg::PW-1:0]   yv,
  input  wire logic signed [qe_pkg::PW-1:0]   xv,
  output logic [qe_pkg::BW-1:0]               bin
);
  localparam int N  = (STEPS > 32) ? 32 : STEPS;
  localparam int CW = qe_pkg::CW;
  localparam int AW = qe_pkg::AW;

  // quadrant/axis flags travel alongside
  typedef struct packed {
    logic yz, xz, xneg, yneg, ypos;
  } quad_t;

  // stage 0: magnitudes (both < 2^36 so no pre-scale needed)
  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [AW-1:0] z_r [0:N];
  quad_t                q_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= xv[qe_pkg::PW-1] ? CW'(-$signed({xv[qe_pkg::PW-1], xv}))
                                 : CW'($signed({1'b0, xv}));
      y_r[0] <= yv[qe_pkg::PW-1] ? CW'(-$signed({yv[qe_pkg::PW-1], yv}))
                                 : CW'($signed({1'b0, yv}));
      z_r[0] <= '0;
      q_r[0] <= '{yz: (yv == '0), xz: (xv == '0), xneg: xv[qe_pkg::PW-1],
                  yneg: yv[qe_pkg::PW-1], ypos: (yv != '0) && !yv[qe_pkg::PW-1]};
    end
  end

  // CORDIC vectoring stages
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + qe_pkg::atan_units(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - qe_pkg::atan_units(i);
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // fold into quadrant, register the angle
  localparam logic signed [AW-1:0] QT = AW'(64'sd1 <<< 30);
  localparam logic signed [AW-1:0] HT = AW'(64'sd1 <<< 31);
  logic signed [AW-1:0] zc, ang_nxt;
  logic [AW-1:0] ang_r;
  always_comb begin
    zc = z_r[N];
    if (zc < AW'(1)) zc = AW'(1);
    if (zc > QT - AW'(1)) zc = QT - AW'(1);
    if (q_r[N].yz) ang_nxt = q_r[N].xneg ? HT : '0;
    else if (q_r[N].xz) ang_nxt = q_r[N].ypos ? QT : -QT;
    else if (!q_r[N].xneg) ang_nxt = q_r[N].ypos ? zc : -zc;
    else ang_nxt = q_r[N].ypos ? (HT - zc) : -(HT - zc);
  end
  always_ff @(posedge clk) begin
    if (en) ang_r <= AW'(ang_nxt + HT);
  end

  // bin = (u * BINS) >> 32, u below 2^33
  logic [AW+8-1:0] prod;
  assign prod = (AW+8)'(ang_r) * (AW+8)'(BINS);
  logic [qe_pkg::BW-1:0] bin_r;
  always_ff @(posedge clk) begin
    if (en) bin_r <= prod[32 +: qe_pkg::BW];
  end
  assign bin = bin_r;
endmodule
`default_nettype wire

FILE: sv/qe_checker.sv
// Port-level checker for the top level, bound in below.
// Depends on assert_macros.svh and qe_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module qe_checker #(parameter int BINS = qe_pkg::BINS_DEF) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [qe_pkg::BW-1:0] roll_bin,
  input wire logic [qe_pkg::BW-1:0] pitch_bin
);
  `QE_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `QE_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready)
  `QE_ASSERT_IMP(a_roll, clk, rst_n, out_valid, roll_bin <= qe_pkg::BW'(BINS))
  `QE_ASSERT_IMP(a_pitch, clk, rst_n, out_valid, pitch_bin <= qe_pkg::BW'(BINS))
endmodule
bind quaternion_to_euler_bins_top qe_checker #(.BINS(BINS)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .roll_bin(out_ch.data.roll), .pitch_bin(out_ch.data.pitch));
`default_nettype wire

FILE: sim/quaternion_to_euler_bins_top_tb.sv
// Testbench for quaternion_to_euler_bins_top: random and directed quaternions,
// bins predicted in the bench and checked in order. Depends on qe_pkg, qe_if.
`timescale 1ns / 1ps
module quaternion_to_euler_bins_top_tb;

  localparam int NBINS     = 18;
  localparam int FRACB     = 14;
  localparam int NSTEPS    = 16;
  localparam int N_RANDOM  = 1300;
  localparam int QUIET_N   = 200;   // last items run with no idling
  localparam int WDOG_MAX  = 3000;
  localparam int DRAIN_CYC = NSTEPS + 30;

  // Orientation predictor plus queue of expected bin triples
  class euler_bin_board;
    qe_pkg::bins_item_t pending[$];
    longint     edge_sine[NBINS];
    int         fails;
    longint     angle_step[32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000};

    function new();
      longint e;
      fails = 0;
      for (int j = 1; j < NBINS; j++) begin
        e = -(64'sd1 <<< 30) + longint'((64'(j) << 31) / 64'(NBINS));
        edge_sine[j] = rotate_sine(e);
      end
    endfunction

    // sine in Q1.30 by CORDIC rotation
    function longint rotate_sine(longint theta);
      longint cx, cy, cz, dx, dy;
      cx = 652032874; cy = 0; cz = theta;
      for (int i = 0; i < NSTEPS; i++) begin
        dx = cy >>> i; dy = cx >>> i;
        if (cz >= 0) begin
          cx -= dx; cy += dy; cz -= angle_step[i];
        end else begin
          cx += dx; cy -= dy; cz += angle_step[i];
        end
      end
      if (cy > (64'sd1 <<< 30)) cy = 64'sd1 <<< 30;
      if (cy < -(64'sd1 <<< 30)) cy = -(64'sd1 <<< 30);
      return cy;
    endfunction

    // atan2 in angle units, 2^32 per turn
    function longint vector_angle(longint yv, longint xv);
      longint ax, ay, cx, cy, cz, dx, dy;
      if (yv == 0) return (xv < 0) ? (64'sd1 <<< 31) : 0;
      if (xv == 0) return (yv > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
      ax = (xv < 0) ? -xv : xv;
      ay = (yv < 0) ? -yv : yv;
      while (ax >= (64'sd1 <<< 40) || ay >= (64'sd1 <<< 40)) begin
        ax = ax >>> 1; ay = ay >>> 1;
      end
      cx = ax; cy = ay; cz = 0;
      for (int i = 0; i < NSTEPS; i++) begin
        dx = cy >>> i; dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx; cy -= dy; cz += angle_step[i];
        end else begin
          cx -= dx; cy += dy; cz -= angle_step[i];
        end
      end
      if (cz < 1) cz = 1;
      if (cz > (64'sd1 <<< 30) - 1) cz = (64'sd1 <<< 30) - 1;
      if (xv > 0) return (yv > 0) ? cz : -cz;
      return (yv > 0) ? ((64'sd1 <<< 31) - cz) : -((64'sd1 <<< 31) - cz);
    endfunction

    function qe_pkg::bin_t turn_bin(longint ang);
      longint unsigned u;
      u = longint'(ang + (64'sd1 <<< 31));
      return qe_pkg::bin_t'((u * NBINS) >> 32);
    endfunction

    function qe_pkg::bin_t pitch_bin(longint s);
      longint unity, sq;
      int cnt;
      unity = 64'sd1 <<< (2 * FRACB);
      if (s > unity) s = unity;
      if (s < -unity) s = -unity;
      if (2 * FRACB >= 30) sq = s >>> (2 * FRACB - 30);
      else sq = s * (64'sd1 <<< (30 - 2 * FRACB));
      cnt = 0;
      for (int j = 1; j < NBINS; j++) if (sq >= edge_sine[j]) cnt++;
      if (sq >= (64'sd1 <<< 30)) cnt++;
      return qe_pkg::bin_t'(cnt);
    endfunction

    function void note_quat(qe_pkg::quat_item_t q);
      longint w, x, y, z, unity;
      qe_pkg::bins_item_t b;
      w = q.w; x = q.x; y = q.y; z = q.z;
      unity = 64'sd1 <<< (2 * FRACB);
      b.roll  = turn_bin(vector_angle(2 * (w * x + y * z), unity - 2 * (x * x + y * y)));
      b.pitch = pitch_bin(2 * (w * y - z * x));
      b.yaw   = turn_bin(vector_angle(2 * (w * z + x * y), unity - 2 * (y * y + z * z)));
      pending.push_back(b);
    endfunction

    function void check_bins(qe_pkg::bins_item_t got);
      qe_pkg::bins_item_t want;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result item %p", got);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        fails++;
        if (fails <= 10)
          $display("bin mismatch: expected roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                   want.roll, want.pitch, want.yaw, got.roll, got.pitch, got.yaw);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  qe_if #(.T(qe_pkg::quat_item_t)) in_ch (clk);
  qe_if #(.T(qe_pkg::bins_item_t)) out_ch (clk);

  quaternion_to_euler_bins_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  euler_bin_board board = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;

  // receiver stalls in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // outputs are stable from negedge to the next posedge
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_bins(out_ch.data);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_quat(qe_pkg::quat_item_t q, int gap);
    bit acc;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= q;
    do begin
      @(negedge clk);
      acc = in_ch.ready;
      if (acc) board.note_quat(q);
      @(posedge clk);
    end while (!acc);
  endtask

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 14);
  endfunction

  function automatic qe_pkg::quat_item_t mk(int w, int x, int y, int z);
    qe_pkg::quat_item_t q;
    q.w = qe_pkg::quat_t'(w); q.x = qe_pkg::quat_t'(x);
    q.y = qe_pkg::quat_t'(y); q.z = qe_pkg::quat_t'(z);
    return q;
  endfunction

  // random unit quaternion, truncated toward zero to Q2.14
  function automatic qe_pkg::quat_item_t unit_quat();
    real c[4];
    real norm;
    int v[4];
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'(int'($urandom_range(0, 65536)) - 32768);
      norm += c[i] * c[i];
    end
    if (norm == 0.0) return mk(16384, 0, 0, 0);
    norm = $sqrt(norm);
    for (int i = 0; i < 4; i++) v[i] = $rtoi(c[i] / norm * 16384.0);
    return mk(v[0], v[1], v[2], v[3]);
  endfunction

  function automatic qe_pkg::quat_item_t random_quat();
    qe_pkg::quat_item_t q;
    int sel;
    sel = $urandom_range(0, 9);
    q = unit_quat();
    if (sel == 0) begin
      q = qe_pkg::quat_item_t'({$urandom, $urandom});      // any bit pattern
    end else if (sel == 1) begin
      case ($urandom_range(0, 3))                  // land on an atan2 axis
        0: begin q.y = '0; q.z = '0; end
        1: begin q.x = '0; q.y = '0; end
        2: begin q.w = '0; q.z = '0; end
        default: begin q.w = '0; q.x = '0; end
      endcase
    end else if (sel == 2) begin
      // plus or minus one on a single component
      q = mk($urandom_range(0, 1) ? 16384 : -16384, 0, 0, 0);
      q = qe_pkg::quat_item_t'(q >> (16 * $urandom_range(0, 3)));
    end
    return q;
  endfunction

  initial begin
    qe_pkg::quat_item_t directed[$];
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, single axes, signs, gimbal lock both ways, range ends
    directed = '{mk(16384, 0, 0, 0), mk(0, 16384, 0, 0), mk(0, 0, 16384, 0),
                 mk(0, 0, 0, 16384), mk(-16384, 0, 0, 0), mk(0, -16384, 0, 0),
                 mk(0, 0, -16384, 0), mk(0, 0, 0, -16384), mk(0, 0, 0, 0),
                 mk(8192, 8192, 8192, -8192), mk(8192, -8192, -8192, -8192),
                 mk(11585, 0, 11585, 0), mk(11585, 0, -11585, 0),
                 mk(11585, 11585, 0, 0), mk(11585, 0, 0, 11585),
                 mk(11585, 0, 0, -11585), mk(32767, 32767, 32767, 32767),
                 mk(-32768, -32768, -32768, -32768), mk(32767, -32768, 32767, -32768),
                 mk(8192, 8192, 8192, 8192), mk(1, 0, 0, 0), mk(0, 1, -1, 0),
                 mk(16383, 181, -181, 90)};
    foreach (directed[i]) send_quat(directed[i], pick_gap());

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        wait (board.pending.size() == 0);
        @(posedge clk);
      end
      if (n == N_RANDOM - QUIET_N) quiet = 1'b1;
      send_quat(random_quat(), pick_gap());
    end
    in_ch.valid <= 1'b0;

    wait (board.pending.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/qe_pkg.sv
sv/qe_if.sv
sv/qe_atan2_bin.sv
sv/quaternion_to_euler_bins_top.sv
sv/qe_checker.sv
sim/quaternion_to_euler_bins_top_tb.sv
